/* sv/tdm_pkg.sv */
// constants for the tone divider to midi converter
// no dependencies; imported by tone_divider_to_midi
`default_nettype none

package tdm_pkg;

  // default configuration of the block
  localparam int CHANNELS_DEF     = 4;
  localparam int DIVIDER_BITS_DEF = 14;

  // log2 datapath: q30 mantissa in [1,2), 16 fraction bits
  localparam int MANT_W    = 31;
  localparam int FRAC_BITS = 16;
  localparam int NOTE_W    = 24;

  // 65536 * (69 + 12*log2(781250/440)), note offset in q16
  localparam logic [NOTE_W-1:0] NOTE_K_Q16 = 24'd13010782;

  // midi status bases
  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_BEND     = 8'he0;

  // register reset values
  localparam logic [7:0] NOTE_LIMIT_RST = 8'd90;
  localparam logic [6:0] VELOCITY_RST   = 7'd127;

  // register index, taken from paddr[2]
  localparam logic REG_NOTE_LIMIT = 1'b0;
  localparam logic REG_VELOCITY   = 1'b1;

  // output word: status, data_one, data_two packed into 3 bytes
  localparam int OUT_W = 24;

endpackage

`default_nettype wire

/* sv/tone_divider_to_midi.sv */
// tone divider to midi converter: log2 by repeated squaring, note store in a ram
// depends on tdm_pkg
// sequence: an accepted word passes S_LOAD, the squaring steps in S_LOG, S_CALC and
//   S_DECIDE (a zero divider skips S_LOG and S_CALC); messages then leave one per cycle while m_tready is high
// throughput: a new input word is taken only in S_IDLE, once the last one is through; the
//   16 squaring steps run one after another on the single 31x31 multiplier
// reset: synchronous, active high; clears the control state, the note valid
//   bits (all stored notes read as 0) and loads note_limit 90, velocity 127
`default_nettype none

module tone_divider_to_midi
  import tdm_pkg::*;
#(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int DIVIDER_BITS = DIVIDER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream: [1:0] channel, [DIVIDER_BITS+1:2] divider, rest zero
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [((DIVIDER_BITS+2+7)/8)*8-1:0] s_tdata,
  // output stream: [7:0] status, [14:8] data_one, [21:15] data_two, rest zero
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_W-1:0]           m_tdata,
  output logic                       m_tlast,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int E_W   = $clog2(DIVIDER_BITS);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_LOG    = 6'b000100,
    S_CALC   = 6'b001000,
    S_DECIDE = 6'b010000,
    S_SEND   = 6'b100000
  } state_t;

  state_t state;

  // configuration registers
  logic [7:0] note_limit;
  logic [6:0] velocity;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      note_limit <= NOTE_LIMIT_RST;
      velocity   <= VELOCITY_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_NOTE_LIMIT: note_limit <= pwdata[7:0];
        REG_VELOCITY:   velocity   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NOTE_LIMIT: prdata = {24'd0, note_limit};
      REG_VELOCITY:   prdata = {25'd0, velocity};
      default:        prdata = 32'd0;
    endcase
  end

  // input word fields
  logic [1:0]              in_ch;
  logic [DIVIDER_BITS-1:0] in_div;
  logic                    in_acc;

  assign in_ch    = s_tdata[1:0];
  assign in_div   = s_tdata[DIVIDER_BITS+1:2];
  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid & s_tready;

  // note store: ram of the last note played on each channel, valid bits make unwritten entries read 0
  logic [7:0]          note_mem [CHANNELS];
  logic [CHANNELS-1:0] note_vld;
  logic [7:0]          rd_note;
  logic                rd_vld;
  logic [CH_AW-1:0]    in_addr;
  logic [CH_AW-1:0]    addr;
  logic                mem_we;
  logic [7:0]          note;

  assign in_addr = CH_AW'(in_ch);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_note <= note_mem[in_addr];
    end
    if (mem_we) begin
      note_mem[addr] <= note;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      note_vld <= '0;
      rd_vld   <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_vld <= note_vld[in_addr];
      end
      if (mem_we) begin
        note_vld[addr] <= 1'b1;
      end
    end
  end

  // held item
  logic [1:0]              ch;
  logic [DIVIDER_BITS-1:0] div;
  logic                    ch_ok;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch    <= in_ch;
      div   <= in_div;
      addr  <= in_addr;
      ch_ok <= (5'(in_ch) < 5'(CHANNELS));
    end
  end

  // leading one of the divider gives the integer part of log2
  logic [E_W-1:0] lead;

  always_comb begin
    lead = '0;
    for (int i = 0; i < DIVIDER_BITS; i++) begin
      if (div[i]) lead = E_W'(i);
    end
  end

  logic [MANT_W-1:0]   div_ext;
  logic [4:0]          shamt;
  logic [MANT_W-1:0]   mant;
  logic [E_W-1:0]      expo;
  logic [FRAC_BITS-1:0] frac;
  logic [3:0]          step;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sq_hi;

  assign div_ext = MANT_W'(div);
  assign shamt   = 5'(MANT_W - 1) - 5'(lead);
  assign sq      = mant * mant;
  assign sq_hi   = sq[2*MANT_W-1:MANT_W-1];

  // note in q12 from 12*log2 in q16
  logic [NOTE_W-1:0] lg;
  logic [NOTE_W-1:0] t12;
  logic [NOTE_W-1:0] diff;
  logic [19:0]       q12;

  assign lg   = NOTE_W'({expo, frac});
  assign t12  = (lg << 3) + (lg << 2);
  assign diff = NOTE_K_Q16 - t12;
  assign q12  = (t12 > NOTE_K_Q16) ? 20'd0 : diff[NOTE_W-1:4];

  logic [13:0] bend;
  logic [7:0]  old_note;
  logic        play;
  logic [7:0]  cur_old;
  logic        cur_play;
  logic [1:0]  msg;
  logic        msg_last;
  logic        out_free;

  assign cur_old  = rd_vld ? rd_note : 8'd0;
  assign cur_play = (div != '0) && (note < note_limit);
  assign mem_we   = (state == S_DECIDE) && ch_ok && (cur_old != note) && cur_play;
  assign out_free = !m_tvalid || m_tready;
  assign msg_last = (msg == 2'd2) || ((msg == 2'd0) && !play);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      msg   <= 2'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) state <= S_LOAD;
        end
        S_LOAD: begin
          state <= (div == '0) ? S_DECIDE : S_LOG;
        end
        S_LOG: begin
          if (step == 4'(FRAC_BITS - 1)) state <= S_CALC;
        end
        S_CALC: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          msg <= 2'd0;
          if (ch_ok && (cur_old != note)) begin
            state <= S_SEND;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SEND: begin
          if (out_free) begin
            msg <= msg + 2'd1;
            if (msg_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // log2 datapath: mantissa load, squaring steps, note and bend, old note and play flag
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        mant <= div_ext << shamt;
        expo <= lead;
        frac <= '0;
        step <= 4'd0;
        note <= 8'd0;
      end
      S_LOG: begin
        step <= step + 4'd1;
        if (sq_hi[MANT_W]) begin
          mant <= sq_hi[MANT_W:1];
          frac <= {frac[FRAC_BITS-2:0], 1'b1};
        end else begin
          mant <= sq_hi[MANT_W-1:0];
          frac <= {frac[FRAC_BITS-2:0], 1'b0};
        end
      end
      S_CALC: begin
        note <= q12[19:12];
        bend <= {2'b10, q12[11:0]};
      end
      S_DECIDE: begin
        old_note <= cur_old;
        play     <= cur_play;
      end
      default: ;
    endcase
  end

  // output register
  logic [7:0] st_base;
  logic [6:0] d_one;
  logic [6:0] d_two;

  always_comb begin
    case (msg)
      2'd0: begin
        st_base = ST_NOTE_OFF;
        d_one   = old_note[6:0];
        d_two   = 7'd0;
      end
      2'd1: begin
        st_base = ST_NOTE_ON;
        d_one   = note[6:0];
        d_two   = velocity;
      end
      default: begin
        st_base = ST_BEND;
        d_one   = bend[6:0];
        d_two   = bend[13:7];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_SEND && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SEND && out_free) begin
      m_tdata <= {2'b00, d_two, d_one, st_base + 8'(ch)};
      m_tlast <= msg_last;
    end
  end

endmodule

`default_nettype wire
